>>> rtl/rbmi_pkg.sv
// Package for the rigid body motion integrator: op codes, controller states,
// and the command/status structs shared by controller and datapath.
// No dependencies.
package rbmi_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_ACCEL   = 3'd1,
    OP_IMPULSE = 3'd2,
    OP_SET_VEL = 3'd3,
    OP_SET_SPN = 3'd4,
    OP_SET_POS = 3'd5,
    OP_SET_ROT = 3'd6,
    OP_NONE    = 3'd7
  } op_t;

  // Datapath micro-operations issued by the controller.
  typedef enum logic [3:0] {
    UOP_IDLE,
    UOP_LOAD,
    UOP_ACCEL_SUM,
    UOP_VEL_MUL,
    UOP_LIN_DIV,
    UOP_ROT_MUL,
    UOP_ANG_DIV,
    UOP_POS_MUL,
    UOP_IMP_DIV,
    UOP_SETS,
    UOP_FINISH
  } uop_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACCEL,
    ST_VEL,
    ST_LDIV,
    ST_ROT,
    ST_ADIV,
    ST_POS,
    ST_IDIV,
    ST_SETS,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    uop_t       uop;
    logic [1:0] axis;
    logic       start;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic accel_nz;
    logic spin_nz;
    logic lin_on;
    logic ang_on;
    logic dt_nz;
  } status_t;

  localparam int CFG_MASS = 0;
  localparam int CFG_LIN  = 1;
  localparam int CFG_ANG  = 2;

endpackage

>>> rtl/rbmi_if.sv
// Valid/ready channel carrying a packed payload.
// Depends on nothing.
interface rbmi_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/rigid_body_motion_integrator_core.sv
// Rigid body motion integrator: semi-implicit Euler with damping.
// Set and add ops, op seven and a zero duration tick do not use the divider;
// an impulse and some damped ticks use the shared one-bit-per-cycle
// divider, one axis at a time. The result is offered in the output state
// and held until taken. Synchronous active-high reset clears the state
// vectors, sets mass to 1.0, damping 0.
module rigid_body_motion_integrator_core import rbmi_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  rbmi_if.sink        in_ch,
  rbmi_if.source      out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data
);

  cmd_t    cmd;
  status_t status;
  logic in_ready, out_valid;
  logic [31:0] rp [3], rv [3], rr [3];
  logic st, mv, sa;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  // Result layout: pos xyz, vel xyz, rot xyz, stepped, moved, saturated.
  assign out_ch.data = {rp[0], rp[1], rp[2], rv[0], rv[1], rv[2],
                        rr[0], rr[1], rr[2], st, mv, sa};

  rbmi_ctrl u_ctrl (
    .clk, .rst,
    .in_fire  (in_ch.valid & in_ready),
    .in_op    (in_ch.data[118:116]),
    .out_fire (out_valid & out_ch.ready),
    .status, .cmd, .in_ready, .out_valid
  );

  // Input layout: op, step_seconds, vec xyz.
  rbmi_datapath #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst, .cmd, .status,
    .in_op (in_ch.data[118:116]),
    .in_dt (in_ch.data[115:96]),
    .in_vx (in_ch.data[95:64]),
    .in_vy (in_ch.data[63:32]),
    .in_vz (in_ch.data[31:0]),
    .cfg_we, .cfg_idx, .cfg_data,
    .res_pos (rp), .res_vel (rv), .res_rot (rr),
    .res_stepped (st), .res_moved (mv), .res_sat (sa)
  );

endmodule

>>> rtl/rbmi_ctrl.sv
// Controller state machine: sequences one item through the datapath.
// Depends on rbmi_pkg.
module rbmi_ctrl import rbmi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_fire,
  input  logic [2:0] in_op,
  input  logic    out_fire,
  input  status_t status,
  output cmd_t    cmd,
  output logic    in_ready,
  output logic    out_valid
);

  state_t state, state_next;
  logic [1:0] axis, axis_next;
  logic [2:0] op;
  logic issued, issued_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      axis   <= 2'd0;
      issued <= 1'b0;
    end else begin
      state  <= state_next;
      axis   <= axis_next;
      issued <= issued_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) op <= in_op;
  end

  // Next state: multi-cycle steps wait for the divider, per axis.
  always_comb begin
    state_next  = state;
    axis_next   = axis;
    issued_next = 1'b0;
    case (state)
      ST_IDLE: if (in_fire) begin
        axis_next = 2'd0;
        case (in_op)
          OP_TICK:    state_next = ST_ACCEL;
          OP_IMPULSE: state_next = ST_IDIV;
          default:    state_next = ST_SETS;
        endcase
      end
      ST_ACCEL: begin
        if (!status.dt_nz) state_next = ST_FIN;
        else if (status.accel_nz) state_next = ST_VEL;
        else if (status.lin_on) state_next = ST_LDIV;
        else if (status.spin_nz) state_next = ST_ROT;
        else state_next = ST_POS;
      end
      ST_VEL: begin
        if (status.lin_on) state_next = ST_LDIV;
        else if (status.spin_nz) state_next = ST_ROT;
        else state_next = ST_POS;
      end
      ST_LDIV, ST_ADIV, ST_IDIV: begin
        issued_next = 1'b1;
        if (issued && !status.busy) begin
          issued_next = 1'b0;
          if (axis == 2'd2) begin
            axis_next = 2'd0;
            case (state)
              ST_LDIV: state_next = status.spin_nz ? ST_ROT : ST_POS;
              ST_ADIV: state_next = ST_POS;
              default: state_next = ST_FIN;
            endcase
          end else begin
            axis_next = axis + 2'd1;
            issued_next = 1'b0;
          end
        end
      end
      ST_ROT:  state_next = status.ang_on ? ST_ADIV : ST_POS;
      ST_POS:  state_next = ST_FIN;
      ST_SETS: state_next = ST_FIN;
      ST_FIN:  state_next = ST_OUT;
      ST_OUT:  if (out_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: command to the datapath and handshake flags.
  always_comb begin
    cmd.uop   = UOP_IDLE;
    cmd.axis  = axis;
    cmd.start = 1'b0;
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    case (state)
      ST_IDLE:  cmd.uop = in_fire ? UOP_LOAD : UOP_IDLE;
      ST_ACCEL: cmd.uop = UOP_ACCEL_SUM;
      ST_VEL:   cmd.uop = UOP_VEL_MUL;
      ST_LDIV: begin cmd.uop = UOP_LIN_DIV; cmd.start = !issued; end
      ST_ROT:   cmd.uop = UOP_ROT_MUL;
      ST_ADIV: begin cmd.uop = UOP_ANG_DIV; cmd.start = !issued; end
      ST_POS:   cmd.uop = UOP_POS_MUL;
      ST_IDIV: begin cmd.uop = UOP_IMP_DIV; cmd.start = !issued; end
      ST_SETS:  cmd.uop = (op == OP_NONE) ? UOP_IDLE : UOP_SETS;
      ST_FIN:   cmd.uop = UOP_FINISH;
      default:  cmd.uop = UOP_IDLE;
    endcase
  end

`ifndef SYNTH
  a_out_one_cycle: assert property (@(posedge clk) disable iff (rst)
    out_fire |=> state == ST_IDLE) else $error("result not retired");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> state == ST_IDLE) else $error("accepted while busy");
  a_axis_range: assert property (@(posedge clk) disable iff (rst)
    axis != 2'd3) else $error("axis out of range");
`endif

endmodule

>>> rtl/rbmi_datapath.sv
// Datapath: state vectors, saturating add/multiply and a shared radix-2
// restoring divider. Depends on rbmi_pkg.
module rbmi_datapath import rbmi_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output status_t     status,
  input  logic [2:0]  in_op,
  input  logic [19:0] in_dt,
  input  logic [31:0] in_vx,
  input  logic [31:0] in_vy,
  input  logic [31:0] in_vz,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  output logic [31:0] res_pos [3],
  output logic [31:0] res_vel [3],
  output logic [31:0] res_rot [3],
  output logic        res_stepped,
  output logic        res_moved,
  output logic        res_sat
);

  localparam int W    = WORD_BITS;
  localparam int PW   = W + 33;          // product of magnitude and 32-bit factor
  localparam int NW   = W + FRAC_BITS;   // dividend width
  localparam int CW   = $clog2(NW + 1);
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [32:0] ONE_Q = 33'(1) << FRAC_BITS;

  logic [31:0] mass;
  logic [23:0] lin_damp, ang_damp;
  logic signed [W-1:0] pos [3], vel [3], rot [3], spin [3], pend [3];
  logic signed [W-1:0] vec [3], old_pos [3], acc [3];
  logic [19:0] dt;
  logic [2:0]  op;
  logic sat, stepped;
  logic [32:0] ddiv;

  // Divider registers.
  logic [NW-1:0] dnum, dquo;
  logic [33:0]   drem;
  logic [CW-1:0] dcnt;
  logic          dbusy, dneg;

  function automatic logic signed [W-1:0] sx32(input logic [31:0] r);
    logic signed [63:0] s;
    s = 64'(signed'(r));
    if (s > 64'(MAXV)) return MAXV;
    if (s < 64'(MINV)) return MINV;
    return W'(s);
  endfunction

  function automatic logic ovf32(input logic [31:0] r);
    logic signed [63:0] s;
    s = 64'(signed'(r));
    return (s > 64'(MAXV)) || (s < 64'(MINV));
  endfunction

  function automatic logic [W:0] add_full(input logic signed [W-1:0] a,
                                          input logic signed [W-1:0] b);
    logic signed [W:0] s;
    logic o;
    s = {a[W-1], a} + {b[W-1], b};
    o = s[W] != s[W-1];
    return {o, o ? (s[W] ? MINV : MAXV) : s[W-1:0]};
  endfunction

  // Saturating signed * unsigned Q product, truncated toward zero.
  function automatic logic [W:0] mul_full(input logic signed [W-1:0] a,
                                          input logic [31:0] b);
    logic [W-1:0] m;
    logic [PW-1:0] p;
    logic [PW-1:0] lim;
    logic n;
    n = a[W-1];
    m = n ? W'(-a) : W'(a);
    p = (PW'(m) * PW'(b)) >> FRAC_BITS;
    lim = PW'(MAXV) + PW'(n);
    if (p > lim) return {1'b1, n ? MINV : MAXV};
    return {1'b0, n ? W'(-p[W-1:0]) : p[W-1:0]};
  endfunction

  function automatic logic nz(input logic signed [W-1:0] v [3]);
    return (v[0] != '0) || (v[1] != '0) || (v[2] != '0);
  endfunction

  logic [W:0] s0 [3], s1 [3], m0 [3];
  logic signed [W-1:0] dsrc;
  logic [W-1:0] dmag;
  logic [33:0] rtry;
  logic [NW-1:0] qlim;

  // The acceleration test looks at the sum that the current step is forming.
  assign status.busy     = dbusy;
  assign status.accel_nz = (s0[0][W-1:0] != '0) || (s0[1][W-1:0] != '0) ||
                           (s0[2][W-1:0] != '0);
  assign status.spin_nz  = nz(spin);
  assign status.lin_on   = lin_damp != '0;
  assign status.ang_on   = ang_damp != '0;
  assign status.dt_nz    = dt != '0;

  // Divider operand selection.
  always_comb begin
    case (cmd.uop)
      UOP_LIN_DIV: dsrc = vel[cmd.axis];
      UOP_ANG_DIV: dsrc = spin[cmd.axis];
      default:     dsrc = vec[cmd.axis];
    endcase
    dmag = dsrc[W-1] ? W'(-dsrc) : W'(dsrc);
    rtry = {drem[32:0], dnum[NW-1]};
    qlim = NW'(MAXV) + NW'(dneg);
  end

  // Per-axis combinational terms for the add and multiply steps.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s0[i] = add_full(pend[i], vec[i]);
      case (cmd.uop)
        UOP_VEL_MUL: m0[i] = mul_full(acc[i], 32'(dt));
        UOP_ROT_MUL: m0[i] = mul_full(spin[i], 32'(dt));
        default:     m0[i] = mul_full(vel[i], 32'(dt));
      endcase
      case (cmd.uop)
        UOP_VEL_MUL: s1[i] = add_full(vel[i], m0[i][W-1:0]);
        UOP_ROT_MUL: s1[i] = add_full(rot[i], m0[i][W-1:0]);
        default:     s1[i] = add_full(pos[i], m0[i][W-1:0]);
      endcase
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mass     <= 32'd65536;
      lin_damp <= '0;
      ang_damp <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        2'(CFG_MASS): if (cfg_data != '0) mass <= cfg_data;
        2'(CFG_LIN):  lin_damp <= cfg_data[23:0];
        2'(CFG_ANG):  ang_damp <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // State vectors and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0; vel[i] <= '0; rot[i] <= '0; spin[i] <= '0; pend[i] <= '0;
      end
      dbusy <= 1'b0;
    end else begin
      case (cmd.uop)
        UOP_LOAD: begin
          vec[0] <= sx32(in_vx); vec[1] <= sx32(in_vy); vec[2] <= sx32(in_vz);
          sat <= ovf32(in_vx) | ovf32(in_vy) | ovf32(in_vz);
          dt <= in_dt; op <= in_op; stepped <= 1'b0;
          for (int i = 0; i < 3; i++) old_pos[i] <= pos[i];
        end
        UOP_ACCEL_SUM: begin
          for (int i = 0; i < 3; i++) begin
            acc[i] <= s0[i][W-1:0];
            if (dt != '0) sat <= sat | s0[0][W] | s0[1][W] | s0[2][W];
          end
          stepped <= dt != '0;
        end
        UOP_VEL_MUL: for (int i = 0; i < 3; i++) begin
          vel[i] <= s1[i][W-1:0];
          if (m0[i][W] | s1[i][W]) sat <= 1'b1;
        end
        UOP_ROT_MUL: for (int i = 0; i < 3; i++) begin
          rot[i] <= s1[i][W-1:0];
          if (m0[i][W] | s1[i][W]) sat <= 1'b1;
        end
        UOP_POS_MUL: for (int i = 0; i < 3; i++) begin
          pos[i] <= s1[i][W-1:0];
          pend[i] <= '0;
          if (m0[i][W] | s1[i][W]) sat <= 1'b1;
        end
        UOP_SETS: begin
          case (op)
            OP_ACCEL: for (int i = 0; i < 3; i++) begin
              pend[i] <= s0[i][W-1:0];
              if (s0[i][W]) sat <= 1'b1;
            end
            OP_SET_VEL: for (int i = 0; i < 3; i++) vel[i] <= vec[i];
            OP_SET_SPN: for (int i = 0; i < 3; i++) spin[i] <= vec[i];
            OP_SET_POS: for (int i = 0; i < 3; i++) pos[i] <= vec[i];
            OP_SET_ROT: for (int i = 0; i < 3; i++) rot[i] <= vec[i];
            default: ;
          endcase
        end
        default: ;
      endcase
      if (cmd.uop == UOP_IDLE && op == OP_NONE) sat <= 1'b0;

      // Divider: start, one quotient bit per cycle, then write back.
      if (cmd.start) begin
        dnum  <= NW'(dmag) << FRAC_BITS;
        dneg  <= dsrc[W-1];
        drem  <= '0;
        dquo  <= '0;
        dcnt  <= CW'(NW);
        dbusy <= 1'b1;
        case (cmd.uop)
          UOP_LIN_DIV: ddiv <= ONE_Q + 33'((48'(lin_damp) * 48'(dt)) >> FRAC_BITS);
          UOP_ANG_DIV: ddiv <= ONE_Q + 33'((48'(ang_damp) * 48'(dt)) >> FRAC_BITS);
          default:     ddiv <= 33'(mass);
        endcase
      end else if (dbusy) begin
        if (dcnt != '0) begin
          dnum <= dnum << 1;
          dcnt <= dcnt - CW'(1);
          if (rtry >= 34'(ddiv)) begin
            drem <= rtry - 34'(ddiv);
            dquo <= {dquo[NW-2:0], 1'b1};
          end else begin
            drem <= rtry;
            dquo <= {dquo[NW-2:0], 1'b0};
          end
        end else begin
          dbusy <= 1'b0;
          begin : wb
            logic signed [W-1:0] q;
            logic o;
            logic [W:0] t;
            o = dquo > qlim;
            q = o ? (dneg ? MINV : MAXV) : (dneg ? W'(-dquo[W-1:0]) : dquo[W-1:0]);
            t = add_full(vel[cmd.axis], q);
            case (cmd.uop)
              UOP_LIN_DIV: begin vel[cmd.axis] <= q; if (o) sat <= 1'b1; end
              UOP_ANG_DIV: begin spin[cmd.axis] <= q; if (o) sat <= 1'b1; end
              default: begin
                vel[cmd.axis] <= t[W-1:0];
                if (o | t[W]) sat <= 1'b1;
              end
            endcase
          end
        end
      end
    end
  end

  // Result fields.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      res_pos[i] = 32'(pos[i]);
      res_vel[i] = 32'(vel[i]);
      res_rot[i] = 32'(rot[i]);
    end
    res_stepped = stepped;
    res_moved   = (pos[0] != old_pos[0]) || (pos[1] != old_pos[1]) || (pos[2] != old_pos[2]);
    res_sat     = sat;
  end

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !dbusy) else $error("divider restarted while busy");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    dbusy |-> ddiv != '0) else $error("zero divisor");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    $rose(dbusy) |-> dcnt == CW'(NW)) else $error("divider count");
`endif

endmodule

>>> dv/rigid_body_motion_integrator_core_tb.sv
// Self-checking testbench for rigid_body_motion_integrator_core: a motion
// predictor in a small scoreboard class checks every result item.
// Depends on rbmi_pkg, rbmi_if and the core itself.
module rigid_body_motion_integrator_core_tb;
  import rbmi_pkg::*;

  localparam longint MAX_W = 64'sd2147483647;
  localparam longint MIN_W = -64'sd2147483648;
  localparam longint CYCLE_LIMIT = 6000000;

  typedef struct packed {
    op_t              op;
    logic [19:0]      dt;
    logic [0:2][31:0] vec;
  } motion_cmd_t;

  typedef struct packed {
    logic [0:2][31:0] pos;
    logic [0:2][31:0] vel;
    logic [0:2][31:0] rot;
    logic             stepped;
    logic             moved;
    logic             saturated;
  } body_state_t;

  // Predicts the body state after each item and keeps the expected results.
  class motion_scoreboard;
    longint pos[3], vel[3], rot[3], spin[3], pend[3];
    longint unsigned mass, lin_damp, ang_damp;
    bit clipped;
    int errors;
    body_state_t expected_states[$];

    function new();
      mass = 65536;
      lin_damp = 0;
      ang_damp = 0;
      errors = 0;
      for (int i = 0; i < 3; i++) begin
        pos[i] = 0; vel[i] = 0; rot[i] = 0; spin[i] = 0; pend[i] = 0;
      end
    endfunction

    function void set_reg(int idx, logic [31:0] value);
      if (idx == CFG_MASS) begin
        if (value != 0) mass = value;
      end else if (idx == CFG_LIN) begin
        lin_damp = value[23:0];
      end else if (idx == CFG_ANG) begin
        ang_damp = value[23:0];
      end
    endfunction

    function longint clip_mag(longint unsigned m, bit neg);
      longint unsigned lim;
      lim = longint'(MAX_W) + (neg ? 1 : 0);
      if (m > lim) begin
        clipped = 1;
        return neg ? MIN_W : MAX_W;
      end
      return neg ? -longint'(m) : longint'(m);
    endfunction

    function longint add_clip(longint a, longint b);
      longint s;
      s = a + b;
      if (s > MAX_W) begin
        clipped = 1;
        return MAX_W;
      end
      if (s < MIN_W) begin
        clipped = 1;
        return MIN_W;
      end
      return s;
    endfunction

    function longint scale(longint a, longint unsigned b);
      longint unsigned m;
      m = (a < 0) ? longint'(-a) : a;
      return clip_mag((m * b) >> 16, a < 0);
    endfunction

    function longint divide(longint a, longint unsigned d);
      longint unsigned m;
      m = (a < 0) ? longint'(-a) : a;
      return clip_mag((m << 16) / d, a < 0);
    endfunction

    // Applies one accepted item to the predicted state.
    function void note_input(motion_cmd_t c);
      longint acc[3], v[3], old_pos[3];
      longint unsigned dt, d;
      bit stepped;
      body_state_t r;
      clipped = 0;
      stepped = 0;
      dt = c.dt;
      for (int i = 0; i < 3; i++) begin
        v[i] = longint'(signed'(c.vec[i]));
        old_pos[i] = pos[i];
      end
      case (c.op)
        OP_TICK: begin
          if (dt != 0) begin
            stepped = 1;
            for (int i = 0; i < 3; i++) acc[i] = add_clip(pend[i], v[i]);
            if (acc[0] != 0 || acc[1] != 0 || acc[2] != 0)
              for (int i = 0; i < 3; i++) vel[i] = add_clip(vel[i], scale(acc[i], dt));
            if (lin_damp != 0) begin
              d = 65536 + ((lin_damp * dt) >> 16);
              for (int i = 0; i < 3; i++) vel[i] = divide(vel[i], d);
            end
            if (spin[0] != 0 || spin[1] != 0 || spin[2] != 0) begin
              for (int i = 0; i < 3; i++) rot[i] = add_clip(rot[i], scale(spin[i], dt));
              if (ang_damp != 0) begin
                d = 65536 + ((ang_damp * dt) >> 16);
                for (int i = 0; i < 3; i++) spin[i] = divide(spin[i], d);
              end
            end
            for (int i = 0; i < 3; i++) begin
              pend[i] = 0;
              pos[i] = add_clip(pos[i], scale(vel[i], dt));
            end
          end
        end
        OP_ACCEL:   for (int i = 0; i < 3; i++) pend[i] = add_clip(pend[i], v[i]);
        OP_IMPULSE: for (int i = 0; i < 3; i++) vel[i] = add_clip(vel[i], divide(v[i], mass));
        OP_SET_VEL: for (int i = 0; i < 3; i++) vel[i] = v[i];
        OP_SET_SPN: for (int i = 0; i < 3; i++) spin[i] = v[i];
        OP_SET_POS: for (int i = 0; i < 3; i++) pos[i] = v[i];
        OP_SET_ROT: for (int i = 0; i < 3; i++) rot[i] = v[i];
        default: clipped = 0;
      endcase
      for (int i = 0; i < 3; i++) begin
        r.pos[i] = pos[i][31:0];
        r.vel[i] = vel[i][31:0];
        r.rot[i] = rot[i][31:0];
      end
      r.stepped = stepped;
      r.moved = (pos[0] != old_pos[0]) || (pos[1] != old_pos[1]) || (pos[2] != old_pos[2]);
      r.saturated = clipped;
      expected_states.push_back(r);
    endfunction

    // Compares one result item with the oldest expected state.
    function void check_result(body_state_t got);
      body_state_t e;
      string ax[3];
      ax = '{"x", "y", "z"};
      if (expected_states.size() == 0) begin
        $error("result item with no expected state pending");
        errors++;
        return;
      end
      e = expected_states.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (got.pos[i] !== e.pos[i]) begin
          $error("pos_%s expected %0d got %0d", ax[i], signed'(e.pos[i]), signed'(got.pos[i]));
          errors++;
        end
        if (got.vel[i] !== e.vel[i]) begin
          $error("vel_%s expected %0d got %0d", ax[i], signed'(e.vel[i]), signed'(got.vel[i]));
          errors++;
        end
        if (got.rot[i] !== e.rot[i]) begin
          $error("rot_%s expected %0d got %0d", ax[i], signed'(e.rot[i]), signed'(got.rot[i]));
          errors++;
        end
      end
      if (got.stepped !== e.stepped) begin
        $error("stepped expected %0d got %0d", e.stepped, got.stepped);
        errors++;
      end
      if (got.moved !== e.moved) begin
        $error("moved expected %0d got %0d", e.moved, got.moved);
        errors++;
      end
      if (got.saturated !== e.saturated) begin
        $error("saturated expected %0d got %0d", e.saturated, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        cfg_we = 0;
  logic [1:0]  cfg_idx = 0;
  logic [31:0] cfg_data = 0;
  bit          send_idle = 0;
  bit          recv_stall = 0;
  int          idle_pct = 78;
  longint      cycles = 0;
  motion_scoreboard sb = new();

  rbmi_if #(.W($bits(motion_cmd_t))) in_ch ();
  rbmi_if #(.W($bits(body_state_t))) out_ch ();

  rigid_body_motion_integrator_core dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Result side: check accepted items and stall at random when asked.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
    if (rst) out_ch.ready <= 0;
    else out_ch.ready <= recv_stall ? ($urandom_range(99) >= idle_pct) : 1'b1;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("[rigid_body_motion_integrator_core] ERROR");
      $finish;
    end
  end

  task automatic send_cmd(op_t op, logic [19:0] dt, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z);
    motion_cmd_t c;
    c.op = op;
    c.dt = dt;
    c.vec[0] = x;
    c.vec[1] = y;
    c.vec[2] = z;
    while (send_idle && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.data <= c;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(c);
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.expected_states.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] value);
    cfg_we <= 1;
    cfg_idx <= idx[1:0];
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, value);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(9))
      0:       return $urandom();
      1:       return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      2:       return 0;
      default: return $urandom_range(1) ? $urandom_range(32'h4_0000)
                                        : -$urandom_range(32'h4_0000);
    endcase
  endfunction

  function automatic logic [19:0] rand_dt();
    case ($urandom_range(9))
      0:       return 20'd0;
      1:       return 20'($urandom());
      2:       return 20'hfffff;
      default: return 20'($urandom_range(1, 20'h2000));
    endcase
  endfunction

  task automatic random_items(int n);
    op_t op;
    for (int k = 0; k < n; k++) begin
      op = op_t'($urandom_range(7));
      if ($urandom_range(2) == 0) op = OP_TICK;
      send_cmd(op, rand_dt(), rand_word(), rand_word(), rand_word());
    end
  endtask

  initial begin
    logic [31:0] masses[5];
    logic [31:0] lin[5];
    logic [31:0] ang[5];
    masses = '{32'h0001_0000, 32'h0000_0001, 32'hffff_ffff, 32'h0003_8000, 32'h0000_4000};
    lin = '{0, 32'h00ff_ffff, 32'h0000_1000, 0, 32'h0001_0000};
    ang = '{0, 32'h0000_0800, 32'h00ff_ffff, 32'h0002_0000, 0};
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed items: extremes, every op and the corner cases.
    send_cmd(OP_TICK, 0, 32'h0001_0000, 0, 0);
    send_cmd(OP_ACCEL, 0, 32'h0002_0000, 32'hffff_0000, 0);
    send_cmd(OP_TICK, 0, 0, 0, 0);
    send_cmd(OP_TICK, 20'h0_4000, 0, 32'h0001_0000, 0);
    send_cmd(OP_SET_VEL, 0, 32'h7fff_ffff, 32'h8000_0000, 0);
    send_cmd(OP_TICK, 20'hfffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_cmd(OP_SET_POS, 0, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_cmd(OP_SET_SPN, 0, 32'h0003_0000, 32'h8000_0000, 32'h7fff_ffff);
    send_cmd(OP_SET_ROT, 0, 32'h7fff_0000, 32'h8000_0000, 1);
    send_cmd(OP_TICK, 20'h1_0000, 0, 0, 0);
    send_cmd(OP_ACCEL, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_cmd(OP_ACCEL, 0, 32'h7fff_ffff, 32'h8000_0000, 1);
    send_cmd(OP_IMPULSE, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000);
    send_cmd(OP_NONE, 20'hfffff, 32'h7fff_ffff, 32'h8000_0000, 0);
    send_cmd(OP_SET_SPN, 0, 0, 0, 0);
    send_cmd(OP_SET_VEL, 0, 0, 0, 0);
    send_cmd(OP_TICK, 20'h0_0001, 0, 0, 0);
    drain();

    // A zero mass write is ignored by the block.
    write_reg(CFG_MASS, 0);
    send_cmd(OP_IMPULSE, 0, 32'h0001_0000, 32'hffff_0000, 32'h0000_0100);
    drain();

    // Random phases over several register settings and idle patterns.
    for (int s = 0; s < 5; s++) begin
      write_reg(CFG_MASS, masses[s]);
      write_reg(CFG_LIN, lin[s]);
      write_reg(CFG_ANG, ang[s]);
      for (int m = 0; m < 4; m++) begin
        send_idle = (m == 1) || (m == 3);
        recv_stall = (m == 2) || (m == 3);
        idle_pct = (m == 3) ? 29 : 78;
        random_items(87);
        if (s == 2 && m == 0) begin
          // Let the block empty out completely before continuing.
          in_ch.valid <= 0;
          while (sb.expected_states.size() != 0) @(posedge clk);
          random_items(5);
        end
      end
      drain();
    end
    send_idle = 0;
    recv_stall = 0;
    drain();

    if (sb.errors == 0 && sb.expected_states.size() == 0) begin
      $display("[rigid_body_motion_integrator_core] OK");
    end else begin
      $display("[rigid_body_motion_integrator_core] ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/rbmi_pkg.sv
rtl/rbmi_if.sv
rtl/rbmi_ctrl.sv
rtl/rbmi_datapath.sv
rtl/rigid_body_motion_integrator_core.sv
dv/rigid_body_motion_integrator_core_tb.sv
